// ===== src/rm7_pkg.sv =====
// Shared types and constants for the running median filter.
// No dependencies; imported by every module under src.
package rm7_pkg;

  localparam int WINDOW      = 7;
  localparam int SAMPLE_BITS = 16;
  localparam int MID         = WINDOW / 2;
  localparam int AGE_BITS    = $clog2(WINDOW);
  localparam int CNT_BITS    = $clog2(WINDOW + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // One sorted slot: value, how many beats it has been in the window, occupied flag.
  typedef struct packed {
    sample_t               value;
    logic [AGE_BITS-1:0]   age;
    logic                  valid;
  } entry_t;

  // Travels low index to high: slot after removal, its "below new sample" flag,
  // and whether the removed slot lies at or below the sender.
  typedef struct packed {
    entry_t ent;
    logic   lt;
    logic   sd;
  } fwd_t;

  // Travels high index to low: current slot and its "below new sample" flag.
  typedef struct packed {
    entry_t ent;
    logic   cmp;
  } back_t;

endpackage

// ===== src/running_median7_filter.sv =====
// Running median over the last 7 samples: a row of sorted cells plus output buffer.
// Takes one sample per cycle while sample_stall is low; the median of each full window is
// registered in the output buffer, from the combinational compare/shift across the cells.
// Stall is raised only while the skid stage holds a beat.
// Synchronous reset empties the window, fill count and output buffer.
// Depends on rm7_pkg, rm7_cell, rm7_obuf.
module running_median7_filter (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  rm7_pkg::sample_t sample,
  input  logic             first,
  output logic             median_valid,
  input  logic             median_stall,
  output rm7_pkg::sample_t median
);
  import rm7_pkg::*;

  logic                fill_count_busy;
  logic [CNT_BITS-1:0] fill_count;
  logic [CNT_BITS-1:0] fill_eff;
  logic [CNT_BITS-1:0] fill_count_next;
  logic                accept;
  logic                full;
  logic                result;
  fwd_t                fwd  [0:WINDOW];
  back_t               back [0:WINDOW];
  entry_t              ent_next [0:WINDOW-1];

  assign sample_stall = fill_count_busy;
  assign accept       = sample_valid & ~sample_stall;

  always_comb begin
    fill_eff        = first ? '0 : fill_count;
    full            = (fill_eff == CNT_BITS'(WINDOW));
    result          = (fill_eff >= CNT_BITS'(WINDOW - 1));
    fill_count_next = full ? fill_eff : fill_eff + CNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
    end
  end

  // lowest cell always sees "insert here" from its left
  assign fwd[0]      = '{ent: '0, lt: 1'b1, sd: 1'b0};
  assign back[WINDOW] = '{ent: '0, cmp: 1'b0};

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    rm7_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (accept),
      .clear    (first),
      .full     (full),
      .x        (sample),
      .fwd_in   (fwd[k]),
      .back_in  (back[k+1]),
      .fwd_out  (fwd[k+1]),
      .back_out (back[k]),
      .ent_next (ent_next[k])
    );
  end

  rm7_obuf u_obuf (
    .clk          (clk),
    .rst          (rst),
    .push         (accept & result),
    .data         (ent_next[MID].value),
    .busy         (fill_count_busy),
    .median_valid (median_valid),
    .median_stall (median_stall),
    .median       (median)
  );

endmodule

// ===== src/rm7_cell.sv =====
// One slot of the sorted window with its local remove/insert update.
// Depends on rm7_pkg.
module rm7_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           clear,
  input  logic           full,
  input  rm7_pkg::sample_t x,
  input  rm7_pkg::fwd_t  fwd_in,
  input  rm7_pkg::back_t back_in,
  output rm7_pkg::fwd_t  fwd_out,
  output rm7_pkg::back_t back_out,
  output rm7_pkg::entry_t ent_next
);
  import rm7_pkg::*;

  entry_t ent;
  entry_t cur;
  entry_t kept;
  logic   cmp;
  logic   rm;
  logic   sd;
  logic   ltp;

  always_comb begin
    cur       = ent;
    cur.valid = ent.valid & ~clear;
    cmp       = cur.valid && ($signed(cur.value) < $signed(x));
    rm        = full && cur.valid && (cur.age == AGE_BITS'(WINDOW - 1));
    sd        = fwd_in.sd | rm;
    // slot contents once the oldest sample is taken out
    kept      = sd ? back_in.ent : cur;
    ltp       = sd ? back_in.cmp : cmp;

    fwd_out.ent = kept;
    fwd_out.lt  = ltp;
    fwd_out.sd  = sd;
    back_out.ent = cur;
    back_out.cmp = cmp;

    if (ltp) begin
      ent_next     = kept;
      ent_next.age = kept.age + AGE_BITS'(1);
    end else if (fwd_in.lt) begin
      ent_next.value = x;
      ent_next.age   = '0;
      ent_next.valid = 1'b1;
    end else begin
      ent_next     = fwd_in.ent;
      ent_next.age = fwd_in.ent.age + AGE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else if (en) begin
      ent <= ent_next;
    end
  end

endmodule

// ===== src/rm7_obuf.sv =====
// Output register with a skid stage for the median channel.
// Depends on rm7_pkg.
module rm7_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rm7_pkg::sample_t data,
  output logic             busy,
  output logic             median_valid,
  input  logic             median_stall,
  output rm7_pkg::sample_t median
);
  import rm7_pkg::*;

  logic    skid_valid;
  sample_t skid_data;
  logic    pop;

  assign pop  = median_valid & ~median_stall;
  assign busy = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!median_valid || pop) begin
        median_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      median_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        median <= skid_data;
      end
    end else if (push) begin
      if (!median_valid || pop) begin
        median <= data;
      end else begin
        skid_data <= data;
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for running_median7_filter: directed table, then random sequences.
// Needs rm7_pkg and the filter RTL; expected medians come from checked table rows, else a local sorted-window model.
module tb_top;
  import rm7_pkg::*;

  localparam int LIMIT      = 200000;
  localparam int DRAIN      = 20;
  localparam int RAND_ITEMS = 625;
  localparam int N_DIR      = 25;

  typedef enum int {VAL_FULL, VAL_NARROW, VAL_EDGE} val_mode_e;

  typedef struct packed {
    sample_t s;
    logic    f;
    logic    chk;
    sample_t want;
  } stim_row_t;

  // Typed medians only where obvious: uniform windows and one swap into a flat window.
  localparam stim_row_t DIR_TAB [N_DIR] = '{
    '{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{16'sh7fff, 1'b0, 1'b1, 16'sh7fff},
    '{16'sh8000, 1'b1, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b0, 1'b1, 16'sh8000},
    '{16'sh0000, 1'b0, 1'b1, 16'sh8000},
    '{16'sh0005, 1'b0, 1'b0, 16'sh0000},
    '{16'sh0005, 1'b0, 1'b0, 16'sh0000},
    '{16'shffff, 1'b0, 1'b0, 16'sh0000},
    '{16'sh0005, 1'b0, 1'b0, 16'sh0000},
    '{16'sh0007, 1'b0, 1'b0, 16'sh0000},
    '{16'sh0064, 1'b1, 1'b0, 16'sh0000},
    '{16'shff9c, 1'b0, 1'b0, 16'sh0000},
    '{16'sh0064, 1'b0, 1'b0, 16'sh0000},
    '{16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{16'shffff, 1'b0, 1'b0, 16'sh0000}
  };

  logic    clk;
  logic    rst;
  logic    sample_valid;
  logic    sample_stall;
  sample_t sample;
  logic    first;
  logic    median_valid;
  logic    median_stall;
  sample_t median;

  // stimulus-side tag travelling with each beat
  logic    cur_chk;
  sample_t cur_want;

  bit      idling;
  int      errors;
  int      cycles;
  sample_t median_q [$];

  // local model of the window
  sample_t ring   [WINDOW];
  sample_t sorted [WINDOW];
  int      oldest;
  int      fill;

  running_median7_filter dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .first        (first),
    .median_valid (median_valid),
    .median_stall (median_stall),
    .median       (median)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // insert x ahead of the first entry >= x among n sorted entries
  task automatic sorted_insert(input int n, input sample_t x);
    int pos;
    pos = 0;
    while (pos < n && sorted[pos] < x) pos++;
    for (int k = n; k > pos; k--) sorted[k] = sorted[k-1];
    sorted[pos] = x;
  endtask

  task automatic take_sample(input sample_t x, input logic f, output bit got,
                             output sample_t med);
    int pos;
    if (f) begin
      fill   = 0;
      oldest = 0;
    end
    if (fill < WINDOW) begin
      sorted_insert(fill, x);
      fill++;
    end else begin
      // drop the first sorted entry equal to the outgoing sample
      pos = 0;
      while (pos < WINDOW && sorted[pos] != ring[oldest]) pos++;
      if (pos >= WINDOW) pos = WINDOW - 1;
      for (int k = pos; k + 1 < WINDOW; k++) sorted[k] = sorted[k+1];
      sorted_insert(WINDOW - 1, x);
    end
    ring[oldest] = x;
    oldest = (oldest + 1 >= WINDOW) ? 0 : oldest + 1;
    got = (fill == WINDOW);
    med = sorted[MID];
  endtask

  function automatic sample_t rand_value(input val_mode_e mode);
    sample_t v;
    case (mode)
      VAL_NARROW: v = sample_t'(int'($urandom_range(6)) - 3);
      VAL_EDGE: begin
        case ($urandom_range(3))
          0: v = 16'sh8000;
          1: v = 16'sh7fff;
          2: v = 16'sh0000;
          default: v = 16'shffff;
        endcase
      end
      default: v = sample_t'($urandom);
    endcase
    return v;
  endfunction

  // one beat: random gap while idling is set, then hold until accepted
  task automatic send(input sample_t s, input logic f, input logic chk, input sample_t want);
    while (idling && $urandom_range(99) < 13) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    first        <= f;
    cur_chk      <= chk;
    cur_want     <= want;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  always @(posedge clk) begin
    median_stall <= idling && ($urandom_range(99) < 13);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // prediction on accepted input beats, checking on accepted output beats
  always @(posedge clk) begin
    bit      got;
    sample_t med;
    sample_t want;
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        take_sample(sample, first, got, med);
        if (got) begin
          median_q.push_back(cur_chk ? cur_want : med);
        end else if (cur_chk) begin
          $display("%0t: expected median %0d, got no result beat", $time, cur_want);
          errors++;
        end
      end
      if (median_valid && !median_stall) begin
        if (median_q.size() == 0) begin
          $display("%0t: unexpected median beat: expected none, got %0d", $time, median);
          errors++;
        end else begin
          want = median_q.pop_front();
          if (median !== want) begin
            $display("%0t: median mismatch: expected %0d, got %0d", $time, want, median);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int        n;
    int        len;
    int        roll;
    val_mode_e mode;
    logic      f;
    errors = 0;
    cycles = 0;
    idling = 1'b1;
    fill   = 0;
    oldest = 0;
    for (int k = 0; k < WINDOW; k++) begin
      ring[k]   = '0;
      sorted[k] = '0;
    end
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    first        <= 1'b0;
    cur_chk      <= 1'b0;
    cur_want     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIR; r++)
      send(DIR_TAB[r].s, DIR_TAB[r].f, DIR_TAB[r].chk, DIR_TAB[r].want);

    n = 0;
    while (n < RAND_ITEMS) begin
      roll = $urandom_range(99);
      mode = val_mode_e'($urandom_range(2));
      if (roll < 85) len = $urandom_range(40, 7);
      else if (roll < 95) len = $urandom_range(6, 1);
      else len = $urandom_range(8, 1);
      for (int k = 0; k < len && n < RAND_ITEMS; k++) begin
        idling = !(n >= 250 && n < 400);
        // noise runs carry a random first flag; the rest flag only their opening beat
        f = (roll >= 95) ? logic'($urandom_range(1)) : (k == 0);
        send(rand_value(mode), f, 1'b0, '0);
        n++;
      end
    end
    sample_valid <= 1'b0;

    while (median_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rm7_pkg.sv
src/rm7_cell.sv
src/rm7_obuf.sv
src/running_median7_filter.sv
dv/tb_top.sv
